/* sv/obstacle_speed_governor_assert.svh */
// Assertion macros shared by the obstacle speed governor checkers.
`ifndef OBSTACLE_SPEED_GOVERNOR_ASSERT_SVH
`define OBSTACLE_SPEED_GOVERNOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define OSG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define OSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/osg_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the speed governor.
package osg_pkg;

    // Default parameter values.
    localparam int MAX_SCAN_POINTS_DEF = 4096;
    localparam int SCALE_FRAC_BITS_DEF = 16;

    // Distance sentinel meaning nothing seen.
    localparam logic [15:0] INF_MM = 16'hFFFF;

    // Forward motion starts strictly above this speed in mm/s.
    localparam logic signed [15:0] FWD_THRESHOLD = 16'sd10;

    // Input opcodes.
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_COMMAND = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_STOP_DIST   = 3'd0;
    localparam logic [2:0] CFG_SLOW_DIST   = 3'd1;
    localparam logic [2:0] CFG_SECTOR_HALF = 3'd2;
    localparam logic [2:0] CFG_SCAN_POINTS = 3'd3;
    localparam logic [2:0] CFG_RANGE_FLOOR = 3'd4;
    localparam logic [2:0] CFG_RANGE_CEIL  = 3'd5;

    // Configuration reset values.
    localparam logic [15:0] RST_STOP_DIST   = 16'd400;
    localparam logic [15:0] RST_SLOW_DIST   = 16'd800;
    localparam logic [11:0] RST_SECTOR_HALF = 12'd40;
    localparam logic [12:0] RST_SCAN_POINTS = 13'd360;
    localparam logic [15:0] RST_RANGE_FLOOR = 16'd120;
    localparam logic [15:0] RST_RANGE_CEIL  = 16'd12000;

    // Result kinds.
    localparam logic KIND_VEL    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Number of results an item produces.
    localparam logic [2:0] RES_NONE = 3'd0;
    localparam logic [2:0] RES_ONE  = 3'd1;
    localparam logic [2:0] RES_TICK = 3'd3;
    localparam logic [2:0] RES_STOP = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic decode;
        logic div_step;
        logic mul_x;
        logic mul_y;
        logic fin;
        logic load_out;
        logic last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] res_count;
        logic       need_scale;
        logic       div_last;
    } t_dp_stat;

    // Magnitude of a 16-bit signed value; the most negative value maps to 32768.
    function automatic logic [15:0] abs16(logic [15:0] v);
        logic [15:0] neg;
        neg = ~v + 16'd1;
        return v[15] ? neg : v;
    endfunction

endpackage

/* sv/osg_dp.sv */
// Datapath of the speed governor: configuration, scan minimum, divider, scaler, result registers.
module osg_dp #(
    parameter int MAX_SCAN_POINTS = osg_pkg::MAX_SCAN_POINTS_DEF,
    parameter int SCALE_FRAC_BITS = osg_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic [1:0]          i_opcode,
    input  logic [15:0]         i_range_mm,
    input  logic                i_range_valid,
    input  logic [11:0]         i_sample_index,
    input  logic                i_last_sample,
    input  logic signed [15:0]  i_lin_x,
    input  logic signed [15:0]  i_lin_y,
    input  logic signed [15:0]  i_lin_z,
    input  logic signed [15:0]  i_ang_x,
    input  logic signed [15:0]  i_ang_y,
    input  logic signed [15:0]  i_ang_z,
    input  osg_pkg::t_dp_cmd    i_cmd,
    output osg_pkg::t_dp_stat   o_stat,
    output logic                o_kind,
    output logic signed [15:0]  o_out_lin_x,
    output logic signed [15:0]  o_out_lin_y,
    output logic signed [15:0]  o_out_lin_z,
    output logic signed [15:0]  o_out_ang_x,
    output logic signed [15:0]  o_out_ang_y,
    output logic signed [15:0]  o_out_ang_z,
    output logic                o_obstacle,
    output logic                o_run_end
);

    localparam int NMAX_W = $clog2(MAX_SCAN_POINTS + 1);
    localparam int NW     = (NMAX_W > 13) ? NMAX_W : 13;
    localparam int SW     = NW + 1;
    localparam int FB     = SCALE_FRAC_BITS;
    localparam int PW     = 16 + FB;
    localparam int DCW    = $clog2(FB);
    localparam logic [NW-1:0]  MAX_N  = NW'(MAX_SCAN_POINTS);
    localparam logic [FB-1:0]  QMIN   = FB'((1 << FB) / 5);
    localparam logic [PW:0]    RND    = (PW + 1)'(1 << (FB - 1));
    localparam logic [DCW-1:0] DIV_LAST = DCW'(FB - 1);

    // Configuration registers.
    logic [15:0] r_stop_dist;
    logic [15:0] r_slow_dist;
    logic [11:0] r_sector_half;
    logic [12:0] r_scan_points;
    logic [15:0] r_range_floor;
    logic [15:0] r_range_ceil;

    // Block state.
    logic [15:0]        r_running_min;
    logic [15:0]        r_front_min;
    logic               r_moving_forward;
    logic signed [15:0] r_held_yaw;

    // Captured input transaction.
    logic [1:0]         r_in_opcode;
    logic [15:0]        r_in_range_mm;
    logic               r_in_range_valid;
    logic [11:0]        r_in_index;
    logic               r_in_last;
    logic signed [15:0] r_in_lin_x;
    logic signed [15:0] r_in_lin_y;
    logic signed [15:0] r_in_lin_z;
    logic signed [15:0] r_in_ang_x;
    logic signed [15:0] r_in_ang_y;
    logic signed [15:0] r_in_ang_z;

    // Divider and scaler.
    logic [15:0]    r_rem;
    logic [15:0]    r_den;
    logic [FB-1:0]  r_quot;
    logic [DCW-1:0] r_div_cnt;
    logic [PW-1:0]  r_prod;
    logic           r_prod_neg;

    // Pending result.
    logic               r_res_kind;
    logic signed [15:0] r_res_lin_x;
    logic signed [15:0] r_res_lin_y;
    logic signed [15:0] r_res_lin_z;
    logic signed [15:0] r_res_ang_x;
    logic signed [15:0] r_res_ang_y;
    logic signed [15:0] r_res_ang_z;
    logic               r_res_obstacle;

    // Output register.
    logic               r_out_kind;
    logic signed [15:0] r_out_lin_x;
    logic signed [15:0] r_out_lin_y;
    logic signed [15:0] r_out_lin_z;
    logic signed [15:0] r_out_ang_x;
    logic signed [15:0] r_out_ang_y;
    logic signed [15:0] r_out_ang_z;
    logic               r_out_obstacle;
    logic               r_out_run_end;

    logic [NW-1:0] w_scan_n;
    logic [NW-1:0] w_center;
    logic          w_in_sector;
    logic [15:0]   w_base_min;
    logic          w_hit;
    logic [15:0]   w_new_min;
    logic          w_fwd;
    logic          w_stop;
    logic          w_slow;
    logic          w_blocked;
    logic [16:0]   w_shifted;
    logic          w_ge;
    logic [15:0]   w_rem_next;
    logic [FB-1:0] w_q;
    logic [PW:0]   w_round_sum;
    logic [16:0]   w_round_mag;
    logic [16:0]   w_round_signed;
    logic [15:0]   w_scaled;

    // Sector bounds: index in [center - half, center + half], clipped to the scan.
    assign w_scan_n = (NW'(r_scan_points) < MAX_N) ? NW'(r_scan_points) : MAX_N;
    assign w_center = w_scan_n >> 1;
    assign w_in_sector = ((SW'(r_in_index) + SW'(r_sector_half)) >= SW'(w_center))
                      && (SW'(r_in_index) <= (SW'(w_center) + SW'(r_sector_half)))
                      && (NW'(r_in_index) < w_scan_n);

    // Running minimum update; index zero starts a new scan.
    assign w_base_min = (r_in_index == 12'd0) ? osg_pkg::INF_MM : r_running_min;
    assign w_hit = w_in_sector && r_in_range_valid
                && (r_in_range_mm > r_range_floor) && (r_in_range_mm < r_range_ceil)
                && (r_in_range_mm < w_base_min);
    assign w_new_min = w_hit ? r_in_range_mm : w_base_min;

    // Velocity command and tick decisions.
    assign w_fwd     = r_in_lin_x > osg_pkg::FWD_THRESHOLD;
    assign w_stop    = w_fwd && (r_front_min < r_stop_dist);
    assign w_slow    = w_fwd && !w_stop && (r_front_min < r_slow_dist);
    assign w_blocked = r_moving_forward && (r_front_min < r_stop_dist);

    // Status toward the controller.
    always_comb begin
        o_stat.res_count  = osg_pkg::RES_NONE;
        o_stat.need_scale = 1'b0;
        case (r_in_opcode)
            osg_pkg::OP_SAMPLE: begin
                o_stat.res_count = r_in_last ? osg_pkg::RES_ONE : osg_pkg::RES_NONE;
            end
            osg_pkg::OP_COMMAND: begin
                o_stat.need_scale = w_slow;
                o_stat.res_count  = w_stop ? osg_pkg::RES_STOP : osg_pkg::RES_ONE;
            end
            osg_pkg::OP_TICK: begin
                o_stat.res_count = w_blocked ? osg_pkg::RES_TICK : osg_pkg::RES_NONE;
            end
            default: begin
                o_stat.res_count = osg_pkg::RES_NONE;
            end
        endcase
        o_stat.div_last = (r_div_cnt == DIV_LAST);
    end

    // Restoring divider step, one quotient bit per cycle.
    assign w_shifted  = {r_rem, 1'b0};
    assign w_ge       = w_shifted >= {1'b0, r_den};
    assign w_rem_next = w_ge ? 16'(w_shifted - {1'b0, r_den}) : w_shifted[15:0];

    // Ratio clamped below at 0.2; it never reaches 1 on the scaling path.
    assign w_q = (r_quot < QMIN) ? QMIN : r_quot;

    // Rounding of the registered product, magnitude rounded half away from zero.
    assign w_round_sum    = {1'b0, r_prod} + RND;
    assign w_round_mag    = w_round_sum[PW:FB];
    assign w_round_signed = r_prod_neg ? (17'd0 - w_round_mag) : w_round_mag;
    assign w_scaled       = w_round_signed[15:0];

    // Configuration and block state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_dist      <= osg_pkg::RST_STOP_DIST;
            r_slow_dist      <= osg_pkg::RST_SLOW_DIST;
            r_sector_half    <= osg_pkg::RST_SECTOR_HALF;
            r_scan_points    <= osg_pkg::RST_SCAN_POINTS;
            r_range_floor    <= osg_pkg::RST_RANGE_FLOOR;
            r_range_ceil     <= osg_pkg::RST_RANGE_CEIL;
            r_running_min    <= osg_pkg::INF_MM;
            r_front_min      <= osg_pkg::INF_MM;
            r_moving_forward <= 1'b0;
            r_held_yaw       <= 16'sd0;
            r_div_cnt        <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    osg_pkg::CFG_STOP_DIST:   r_stop_dist   <= i_cfg_data;
                    osg_pkg::CFG_SLOW_DIST:   r_slow_dist   <= i_cfg_data;
                    osg_pkg::CFG_SECTOR_HALF: r_sector_half <= i_cfg_data[11:0];
                    osg_pkg::CFG_SCAN_POINTS: r_scan_points <= i_cfg_data[12:0];
                    osg_pkg::CFG_RANGE_FLOOR: r_range_floor <= i_cfg_data;
                    osg_pkg::CFG_RANGE_CEIL:  r_range_ceil  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.decode) begin
                r_div_cnt <= '0;
                case (r_in_opcode)
                    osg_pkg::OP_SAMPLE: begin
                        r_running_min <= w_new_min;
                        if (r_in_last) begin
                            r_front_min <= w_new_min;
                        end
                    end
                    osg_pkg::OP_COMMAND: begin
                        r_moving_forward <= w_fwd;
                        r_held_yaw       <= r_in_ang_z;
                    end
                    default: ;
                endcase
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + DCW'(1);
            end
        end
    end

    // Input capture, divider, scaler and pending result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_opcode      <= i_opcode;
            r_in_range_mm    <= i_range_mm;
            r_in_range_valid <= i_range_valid;
            r_in_index       <= i_sample_index;
            r_in_last        <= i_last_sample;
            r_in_lin_x       <= i_lin_x;
            r_in_lin_y       <= i_lin_y;
            r_in_lin_z       <= i_lin_z;
            r_in_ang_x       <= i_ang_x;
            r_in_ang_y       <= i_ang_y;
            r_in_ang_z       <= i_ang_z;
        end
        if (i_cmd.decode) begin
            r_rem          <= r_front_min - r_stop_dist;
            r_den          <= r_slow_dist - r_stop_dist;
            r_res_kind     <= osg_pkg::KIND_VEL;
            r_res_lin_x    <= 16'sd0;
            r_res_lin_y    <= 16'sd0;
            r_res_lin_z    <= 16'sd0;
            r_res_ang_x    <= 16'sd0;
            r_res_ang_y    <= 16'sd0;
            r_res_ang_z    <= 16'sd0;
            r_res_obstacle <= 1'b0;
            case (r_in_opcode)
                osg_pkg::OP_SAMPLE: begin
                    r_res_kind     <= osg_pkg::KIND_REPORT;
                    r_res_obstacle <= w_new_min < r_slow_dist;
                end
                osg_pkg::OP_COMMAND: begin
                    r_res_ang_z <= r_in_ang_z;
                    if (!w_stop && !w_slow) begin
                        r_res_lin_x <= r_in_lin_x;
                        r_res_lin_y <= r_in_lin_y;
                        r_res_lin_z <= r_in_lin_z;
                        r_res_ang_x <= r_in_ang_x;
                        r_res_ang_y <= r_in_ang_y;
                    end
                end
                osg_pkg::OP_TICK: begin
                    r_res_ang_z <= r_held_yaw;
                end
                default: ;
            endcase
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_rem_next;
            r_quot <= {r_quot[FB-2:0], w_ge};
        end
        // Shared multiplier: forward speed first, then sideways speed.
        if (i_cmd.mul_x) begin
            r_prod     <= PW'(osg_pkg::abs16(r_in_lin_x) * w_q);
            r_prod_neg <= r_in_lin_x[15];
        end
        if (i_cmd.mul_y) begin
            r_res_lin_x <= w_scaled;
            r_prod      <= PW'(osg_pkg::abs16(r_in_lin_y) * w_q);
            r_prod_neg  <= r_in_lin_y[15];
        end
        if (i_cmd.fin) begin
            r_res_lin_y <= w_scaled;
        end
        if (i_cmd.load_out) begin
            r_out_kind     <= r_res_kind;
            r_out_lin_x    <= r_res_lin_x;
            r_out_lin_y    <= r_res_lin_y;
            r_out_lin_z    <= r_res_lin_z;
            r_out_ang_x    <= r_res_ang_x;
            r_out_ang_y    <= r_res_ang_y;
            r_out_ang_z    <= r_res_ang_z;
            r_out_obstacle <= r_res_obstacle;
            r_out_run_end  <= i_cmd.last;
        end
    end

    assign o_kind      = r_out_kind;
    assign o_out_lin_x = r_out_lin_x;
    assign o_out_lin_y = r_out_lin_y;
    assign o_out_lin_z = r_out_lin_z;
    assign o_out_ang_x = r_out_ang_x;
    assign o_out_ang_y = r_out_ang_y;
    assign o_out_ang_z = r_out_ang_z;
    assign o_obstacle  = r_out_obstacle;
    assign o_run_end   = r_out_run_end;

endmodule

/* sv/osg_ctrl.sv */
// Controller of the speed governor: sequences decode, division, scaling and result delivery.
module osg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  osg_pkg::t_dp_stat  i_stat,
    output osg_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_DIVIDE = 7'b0000100,
        S_MULX   = 7'b0001000,
        S_MULY   = 7'b0010000,
        S_FIN    = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_load;

    // The output register takes a result when it is empty or being emptied.
    assign w_load = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    // Commands to the datapath.
    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.decode   = (r_state == S_DECODE);
        o_cmd.div_step = (r_state == S_DIVIDE);
        o_cmd.mul_x    = (r_state == S_MULX);
        o_cmd.mul_y    = (r_state == S_MULY);
        o_cmd.fin      = (r_state == S_FIN);
        o_cmd.load_out = w_load;
        o_cmd.last     = (r_cnt == osg_pkg::RES_ONE);
    end

    // Next state and result count.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.need_scale) begin
                    n_state = S_DIVIDE;
                    n_cnt   = osg_pkg::RES_ONE;
                end else if (i_stat.res_count != osg_pkg::RES_NONE) begin
                    n_state = S_EMIT;
                    n_cnt   = i_stat.res_count;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIVIDE: begin
                if (i_stat.div_last) begin
                    n_state = S_MULX;
                end
            end
            S_MULX: begin
                n_state = S_MULY;
            end
            S_MULY: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_cnt = r_cnt - 3'd1;
                    if (r_cnt == osg_pkg::RES_ONE) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid flag.
    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= osg_pkg::RES_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* sv/obstacle_speed_governor.sv */
// Obstacle speed governor top level: controller and datapath.
// A result goes through the DECODE and EMIT states into the output register; a scaled
// velocity command also goes through DIVIDE, MULX, MULY and FIN, the restoring divider
// producing one quotient bit per cycle. A new item is taken only in IDLE, after all
// results of the last one are loaded. Reset loads the default configuration, sets both
// minima to 65535 and clears the moving-forward and output valid flags.
module obstacle_speed_governor #(
    parameter int MAX_SCAN_POINTS = osg_pkg::MAX_SCAN_POINTS_DEF,
    parameter int SCALE_FRAC_BITS = osg_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [15:0]        i_range_mm,
    input  logic               i_range_valid,
    input  logic [11:0]        i_sample_index,
    input  logic               i_last_sample,
    input  logic signed [15:0] i_lin_x,
    input  logic signed [15:0] i_lin_y,
    input  logic signed [15:0] i_lin_z,
    input  logic signed [15:0] i_ang_x,
    input  logic signed [15:0] i_ang_y,
    input  logic signed [15:0] i_ang_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_kind,
    output logic signed [15:0] o_out_lin_x,
    output logic signed [15:0] o_out_lin_y,
    output logic signed [15:0] o_out_lin_z,
    output logic signed [15:0] o_out_ang_x,
    output logic signed [15:0] o_out_ang_y,
    output logic signed [15:0] o_out_ang_z,
    output logic               o_obstacle,
    output logic               o_run_end
);

    osg_pkg::t_dp_cmd  w_cmd;
    osg_pkg::t_dp_stat w_stat;

    // Configuration writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;

    osg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    osg_dp #(
        .MAX_SCAN_POINTS (MAX_SCAN_POINTS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_range_mm     (i_range_mm),
        .i_range_valid  (i_range_valid),
        .i_sample_index (i_sample_index),
        .i_last_sample  (i_last_sample),
        .i_lin_x        (i_lin_x),
        .i_lin_y        (i_lin_y),
        .i_lin_z        (i_lin_z),
        .i_ang_x        (i_ang_x),
        .i_ang_y        (i_ang_y),
        .i_ang_z        (i_ang_z),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_kind         (o_kind),
        .o_out_lin_x    (o_out_lin_x),
        .o_out_lin_y    (o_out_lin_y),
        .o_out_lin_z    (o_out_lin_z),
        .o_out_ang_x    (o_out_ang_x),
        .o_out_ang_y    (o_out_ang_y),
        .o_out_ang_z    (o_out_ang_z),
        .o_obstacle     (o_obstacle),
        .o_run_end      (o_run_end)
    );

endmodule

/* sv/osg_checker.sv */
// Port-level checker of the speed governor and its binding to the top level.
`include "obstacle_speed_governor_assert.svh"

module osg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [2:0]         i_cfg_index,
    input logic [15:0]        i_cfg_data,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [1:0]         i_opcode,
    input logic [15:0]        i_range_mm,
    input logic               i_range_valid,
    input logic [11:0]        i_sample_index,
    input logic               i_last_sample,
    input logic signed [15:0] i_lin_x,
    input logic signed [15:0] i_lin_y,
    input logic signed [15:0] i_lin_z,
    input logic signed [15:0] i_ang_x,
    input logic signed [15:0] i_ang_y,
    input logic signed [15:0] i_ang_z,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_kind,
    input logic signed [15:0] o_out_lin_x,
    input logic signed [15:0] o_out_lin_y,
    input logic signed [15:0] o_out_lin_z,
    input logic signed [15:0] o_out_ang_x,
    input logic signed [15:0] o_out_ang_y,
    input logic signed [15:0] o_out_ang_z,
    input logic               o_obstacle,
    input logic               o_run_end
);

    // A result that is held back stays offered.
    `OSG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")

    // One item is worked on at a time: an accepted transaction closes the input.
    `OSG_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input open right after a transaction")

    // A status report is always the only result of its sample.
    `OSG_ASSERT_NOW(a_report_single, i_clk, i_rst_n, o_out_valid && o_kind, o_run_end, "status report not marked last")

    // A status report carries no velocity.
    `OSG_ASSERT_NOW(a_report_zero, i_clk, i_rst_n, o_out_valid && o_kind, (o_out_lin_x == 16'sd0) && (o_out_lin_y == 16'sd0) && (o_out_ang_z == 16'sd0), "status report with velocity")

    // A velocity result never raises the obstacle flag.
    `OSG_ASSERT_NOW(a_vel_no_flag, i_clk, i_rst_n, o_out_valid && !o_kind, !o_obstacle, "velocity result with obstacle flag")

endmodule

bind obstacle_speed_governor osg_checker u_osg_checker (.*);
